// File: rtl/ipv4_receive_header_filter_assert.svh
// Assertion macros shared by the checker of the IPv4 receive header filter.
`ifndef IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH
`define IPV4_RECEIVE_HEADER_FILTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IPV4RX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define IPV4RX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ipv4rx_pkg.sv
// Types and constants of the IPv4 receive header filter.
package ipv4rx_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int POS_W        = 5;

    typedef logic [POS_W-1:0] ipv4rx_pos_t;

    // Header byte positions of the captured fields.
    localparam ipv4rx_pos_t POS_VER_IHL   = ipv4rx_pos_t'(0);
    localparam ipv4rx_pos_t POS_LEN_HI    = ipv4rx_pos_t'(2);
    localparam ipv4rx_pos_t POS_LEN_LO    = ipv4rx_pos_t'(3);
    localparam ipv4rx_pos_t POS_PROTO     = ipv4rx_pos_t'(9);
    localparam ipv4rx_pos_t POS_SRC_FIRST = ipv4rx_pos_t'(12);
    localparam ipv4rx_pos_t POS_SRC_LAST  = ipv4rx_pos_t'(15);
    localparam ipv4rx_pos_t POS_DST_FIRST = ipv4rx_pos_t'(16);
    localparam ipv4rx_pos_t POS_LAST      = ipv4rx_pos_t'(HEADER_BYTES - 1);
    localparam ipv4rx_pos_t POS_DONE      = ipv4rx_pos_t'(HEADER_BYTES);

    // Verdict codes.
    localparam logic [2:0] VERDICT_ICMP     = 3'd0;
    localparam logic [2:0] VERDICT_TCP      = 3'd1;
    localparam logic [2:0] VERDICT_OTHER    = 3'd2;
    localparam logic [2:0] VERDICT_BAD_CSUM = 3'd3;
    localparam logic [2:0] VERDICT_ADDR     = 3'd4;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [31:0] BROADCAST_IP = 32'hFFFF_FFFF;
    localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_packet;
    } ipv4rx_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_ip;
        logic [5:0]  payload_offset;
        logic [15:0] payload_length;
    } ipv4rx_out_t;

endpackage

// File: rtl/ipv4rx_in_reg.sv
// Input register of the IPv4 receive header filter.
module ipv4rx_in_reg
    import ipv4rx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  ipv4rx_in_t rx_item,
    output logic       item_valid,
    output ipv4rx_in_t item,
    input  logic       consume
);

    logic       valid_reg;
    logic       valid_next;
    ipv4rx_in_t item_reg;

    assign rx_ready   = !valid_reg || consume;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (rx_valid && rx_ready)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            item_reg <= rx_item;
        end
    end

endmodule

// File: rtl/ipv4rx_hdr_core.sv
// Header field capture, checksum accumulation and verdict logic.
module ipv4rx_hdr_core
    import ipv4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  ipv4rx_in_t  item,
    input  logic [31:0] local_ip,
    input  logic        out_free,
    output logic        consume,
    output logic        result_valid,
    output ipv4rx_out_t result
);

    ipv4rx_pos_t pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pend_reg, pend_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    ipv4rx_pos_t pos_eff;
    logic [15:0] sum_eff;
    logic [7:0]  pend_eff;
    logic [16:0] sum_add;
    logic [15:0] sum_fold;
    logic [31:0] dst_full;
    logic [5:0]  offset;
    logic        active;
    logic        is_last;

    // A start mark abandons whatever header was in progress.
    assign pos_eff  = item.start_of_packet ? '0 : pos_reg;
    assign sum_eff  = item.start_of_packet ? '0 : sum_reg;
    assign pend_eff = item.start_of_packet ? '0 : pend_reg;

    assign active  = (pos_eff < POS_DONE);
    assign is_last = (pos_eff == POS_LAST);

    assign sum_add  = {1'b0, sum_eff} + {1'b0, pend_eff, item.data_byte};
    assign sum_fold = sum_add[16] ? (sum_add[15:0] + 16'd1) : sum_add[15:0];
    assign dst_full = {dst_reg[23:0], item.data_byte};
    assign offset   = {ihl_reg, 2'b00};

    assign result_valid = item_valid && is_last;
    assign consume      = item_valid && (!is_last || out_free);

    always_comb
    begin
        result.protocol_number = proto_reg;
        result.source_ip       = src_reg;
        result.payload_offset  = offset;
        result.payload_length  = len_reg - {10'd0, offset};
        if (sum_fold != CSUM_GOOD)
        begin
            result.verdict = VERDICT_BAD_CSUM;
        end
        else if ((dst_full != local_ip) && (dst_full != BROADCAST_IP))
        begin
            result.verdict = VERDICT_ADDR;
        end
        else if (proto_reg == PROTO_ICMP)
        begin
            result.verdict = VERDICT_ICMP;
        end
        else if (proto_reg == PROTO_TCP)
        begin
            result.verdict = VERDICT_TCP;
        end
        else
        begin
            result.verdict = VERDICT_OTHER;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        ihl_next   = ihl_reg;
        len_next   = len_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (consume && active)
        begin
            pos_next = pos_eff + ipv4rx_pos_t'(1);
            sum_next = sum_eff;
            if (pos_eff[0] == 1'b0)
            begin
                pend_next = item.data_byte;
            end
            else
            begin
                pend_next = pend_eff;
                sum_next  = sum_fold;
            end
            case (pos_eff) inside
                POS_VER_IHL:                  ihl_next   = item.data_byte[3:0];
                POS_LEN_HI:                   len_next   = {item.data_byte, len_reg[7:0]};
                POS_LEN_LO:                   len_next   = {len_reg[15:8], item.data_byte};
                POS_PROTO:                    proto_next = item.data_byte;
                [POS_SRC_FIRST:POS_SRC_LAST]: src_next   = {src_reg[23:0], item.data_byte};
                [POS_DST_FIRST:POS_LAST]:     dst_next   = dst_full;
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ihl_reg   <= ihl_next;
        len_reg   <= len_next;
        proto_reg <= proto_next;
        src_reg   <= src_next;
        dst_reg   <= dst_next;
    end

endmodule

// File: rtl/ipv4rx_out_reg.sv
// Result register of the IPv4 receive header filter.
module ipv4rx_out_reg
    import ipv4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_valid,
    input  ipv4rx_out_t result,
    output logic        out_free,
    output logic        res_valid,
    input  logic        res_ready,
    output ipv4rx_out_t res_item
);

    logic        valid_reg;
    logic        valid_next;
    logic        load;
    ipv4rx_out_t res_reg;

    assign out_free  = !valid_reg || res_ready;
    assign load      = result_valid && out_free;
    assign res_valid = valid_reg;
    assign res_item  = res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

endmodule

// File: rtl/ipv4_receive_header_filter.sv
// Top level of the IPv4 receive header filter.
//
//   Channel   Signals                          Moves
//   rx        rx_valid, rx_ready, rx_item      one packet byte with start mark
//   res       res_valid, res_ready, res_item   one verdict per complete header
//   cfg       cfg_valid, cfg_ready, cfg_data   the local IPv4 address
//
// One byte is taken per cycle unless the last header byte waits in the input
// register for the result register to free up. A byte goes into the input
// register, from which the header logic folds it into the running state; on the
// last header byte the verdict goes into the result register and leaves it on res_ready.
// Reset clears the byte position, the running sum and both valid flags, and
// sets the local address to zero.
// A result that waits in the result register holds back the last header byte of
// the next packet and the bytes behind it; all earlier bytes keep flowing.
// Configuration transfers are always taken.
module ipv4_receive_header_filter
    import ipv4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  ipv4rx_in_t  rx_item,
    output logic        res_valid,
    input  logic        res_ready,
    output ipv4rx_out_t res_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0] local_ip_reg;
    logic        item_valid;
    ipv4rx_in_t  item;
    logic        consume;
    logic        out_free;
    logic        result_valid;
    ipv4rx_out_t result;

    // The address register can be written in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_ip_reg <= cfg_data;
        end
    end

    // Input register: holds one byte until the header logic takes it.
    ipv4rx_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_item    (rx_item),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume)
    );

    // Header logic: position counter, ones' complement sum, field capture
    // and the verdict decision on the last header byte.
    ipv4rx_hdr_core u_hdr_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .local_ip     (local_ip_reg),
        .out_free     (out_free),
        .consume      (consume),
        .result_valid (result_valid),
        .result       (result)
    );

    // Result register: separates the result consumer from the byte stream.
    ipv4rx_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result       (result),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res_item     (res_item)
    );

endmodule

// File: rtl/ipv4rx_checker.sv
// Port-level checker of the IPv4 receive header filter, with its bind.
`include "ipv4_receive_header_filter_assert.svh"

module ipv4rx_checker
    import ipv4rx_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input ipv4rx_out_t res_item,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    logic res_stalled;
    logic icmp_match;
    logic tcp_match;
    logic other_match;
    logic res_other;

    assign res_stalled = res_valid && !res_ready;
    assign icmp_match  = (res_item.verdict != VERDICT_ICMP)
                         || (res_item.protocol_number == PROTO_ICMP);
    assign tcp_match   = (res_item.verdict != VERDICT_TCP)
                         || (res_item.protocol_number == PROTO_TCP);
    assign res_other   = res_valid && (res_item.verdict == VERDICT_OTHER);
    assign other_match = (res_item.protocol_number != PROTO_ICMP)
                         && (res_item.protocol_number != PROTO_TCP);

    `IPV4RX_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stalled, res_valid && $stable(res_item), "stalled result changed")
    `IPV4RX_ASSERT_NOW(a_proto_class, clk, rst_n, res_valid, icmp_match && tcp_match, "verdict disagrees with protocol")
    `IPV4RX_ASSERT_NOW(a_other_class, clk, rst_n, res_other, other_match, "other verdict on known protocol")
    `IPV4RX_ASSERT_NOW(a_offset_words, clk, rst_n, res_valid, res_item.payload_offset[1:0] == 2'b00, "offset not whole words")
    `IPV4RX_ASSERT_NOW(a_cfg_taken, clk, rst_n, cfg_valid, cfg_ready, "configuration transfer refused")

endmodule

bind ipv4_receive_header_filter ipv4rx_checker u_checker (.*);
